// File: src/srmt_pkg.sv
// Package for the slab radiation moment tally: sizes, action codes, record type.
// No dependencies.
`default_nettype none
package srmt_pkg;
  localparam int MaxLevels  = 256;
  localparam int Depth      = MaxLevels + 1;
  localparam int AddrW      = $clog2(Depth);
  localparam int LevelW     = 9;
  localparam int TallyW     = 48;
  localparam int HupW       = 32;
  localparam int HdnW       = 33;

  localparam logic [1:0] ACT_STEP  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // one boundary record: J, H, K for both directions (H down kept as magnitude)
  typedef struct packed {
    logic [TallyW-1:0] j_up;
    logic [HupW-1:0]   h_up;
    logic [TallyW-1:0] k_up;
    logic [TallyW-1:0] j_dn;
    logic [HupW-1:0]   h_dn;
    logic [TallyW-1:0] k_dn;
  } rec_t;

  localparam int RecW = $bits(rec_t);
endpackage
`default_nettype wire

// File: src/slab_radiation_moment_tally.sv
// Top level of the slab radiation moment tally: sequencer, tally store, saturating adders.
// Depends on srmt_pkg and srmt_recip.
//
// channel | dir | handshake             | payload
// in_     | in  | in_valid / in_ready   | action, heights, cosine, boundary index
// out_    | out | out_valid / out_ready | crossed count and six tallies
// cfg_    | in  | cfg_valid / cfg_ready | num_levels
//
// A step with crossings: the two floors, then a wait until the reciprocal is done, then
// a read and a write back per crossed boundary (through the one store port), then
// out_valid rises. A step crossing nothing ends after the floors (with zero cosine it
// goes straight to output); a read fetches one record; a clear zeroes every entry.
// After reset a clearing pass over the store runs before the first item is taken.
// The result waits in the output register; a stalled out_ready holds the block.
`default_nettype none
module slab_radiation_moment_tally (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic signed [19:0] in_start_height,
  input  logic signed [19:0] in_end_height,
  input  logic signed [15:0] in_direction_cosine,
  input  logic [8:0]  in_boundary_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_boundaries_crossed,
  output logic [47:0] out_mean_intensity_up,
  output logic [31:0] out_flux_up,
  output logic [47:0] out_pressure_up,
  output logic [47:0] out_mean_intensity_down,
  output logic signed [32:0] out_flux_down,
  output logic [47:0] out_pressure_down,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_num_levels
);
  import srmt_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FLOOR1, S_FLOOR2, S_DIV, S_RD, S_UPD, S_READ1, S_READ2, S_OUT
  } state_t;

  state_t state_r;
  logic [LevelW-1:0] nlev_r;
  logic [AddrW-1:0]  addr_r;
  logic [AddrW-1:0]  hi_r;
  logic [LevelW-1:0] count_r;
  logic              up_r;
  logic signed [19:0] z1_r, z2_r;
  logic [15:0]       mag_r;
  logic signed [29:0] f1_r;
  logic signed [29:0] prod;
  logic [LevelW-1:0] nsel;
  logic              div_start, div_done;
  logic [31:0]       recip_q;
  logic [31:0]       recip_r;
  logic [8:0]        bidx_r;

  rec_t mem [Depth];
  rec_t rd_r;
  rec_t wr_d;
  logic               we;
  logic [AddrW-1:0]   waddr;

  // effective N, clamped into 1..MaxLevels
  always_comb begin
    if (nlev_r == '0) nsel = LevelW'(1);
    else if (nlev_r > LevelW'(MaxLevels)) nsel = LevelW'(MaxLevels);
    else nsel = nlev_r;
  end

  // shared multiplier for both floor computations: z * N, floor by shift
  assign prod = $signed(state_r == S_FLOOR1 ? z1_r : z2_r) * $signed({1'b0, nsel});

  srmt_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (mag_r),
    .done     (div_done),
    .quotient (recip_q)
  );
  assign div_start = (state_r == S_FLOOR1);

  // saturating update of the record just read; all zeros while clearing
  logic [TallyW:0] sj, sk;
  always_comb begin
    sj = {1'b0, up_r ? rd_r.j_up : rd_r.j_dn} + {17'd0, recip_r};
    sk = {1'b0, up_r ? rd_r.k_up : rd_r.k_dn} + {32'd0, mag_r, 1'b0};
    wr_d = rd_r;
    if (up_r) begin
      wr_d.j_up = sj[TallyW] ? '1 : sj[TallyW-1:0];
      wr_d.k_up = sk[TallyW] ? '1 : sk[TallyW-1:0];
      if (rd_r.h_up != '1) wr_d.h_up = rd_r.h_up + HupW'(1);
    end else begin
      wr_d.j_dn = sj[TallyW] ? '1 : sj[TallyW-1:0];
      wr_d.k_dn = sk[TallyW] ? '1 : sk[TallyW-1:0];
      if (rd_r.h_dn != '1) wr_d.h_dn = rd_r.h_dn + HupW'(1);
    end
    if (state_r == S_CLEAR) wr_d = '0;
  end
  assign we    = (state_r == S_CLEAR) || (state_r == S_UPD);
  assign waddr = addr_r;

  // store: one port, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wr_d;
    rd_r <= mem[addr_r];
  end

  // range clipping helpers for the second floor
  logic signed [30:0] lo_s, hi_s, f2;
  always_comb begin
    f2 = 31'(prod >>> 16);
    if (up_r) begin
      lo_s = 31'(f1_r) + 31'sd1;
      hi_s = f2;
    end else begin
      lo_s = f2 + 31'sd1;
      hi_s = 31'(f1_r);
    end
    if (lo_s < 0) lo_s = '0;
    if (hi_s > $signed({22'd0, nsel})) hi_s = $signed({22'd0, nsel});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      addr_r    <= '0;
      count_r   <= '0;
      bidx_r    <= '1;
      nlev_r    <= LevelW'(MaxLevels);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) nlev_r <= cfg_num_levels;
      case (state_r)
        S_CLEAR: begin
          if (addr_r == AddrW'(Depth - 1)) begin
            addr_r  <= '0;
            count_r <= '0;
            // a clear item reports an all-zero result; the reset pass goes to idle
            if (bidx_r == 9'd0) begin
              state_r   <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            addr_r <= addr_r + AddrW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            z1_r    <= in_start_height;
            z2_r    <= in_end_height;
            up_r    <= !in_direction_cosine[15];
            mag_r   <= in_direction_cosine[15] ? 16'(-in_direction_cosine)
                                               : in_direction_cosine;
            count_r <= '0;
            case (in_action)
              ACT_STEP: begin
                bidx_r  <= '1;
                addr_r  <= '0;
                state_r <= (in_direction_cosine == '0) ? S_OUT : S_FLOOR1;
              end
              ACT_READ: begin
                bidx_r  <= in_boundary_index;
                addr_r  <= in_boundary_index[AddrW-1:0];
                state_r <= S_READ1;
              end
              ACT_CLEAR: begin
                bidx_r  <= 9'd0;
                addr_r  <= '0;
                state_r <= S_CLEAR;
              end
              default: begin
                bidx_r  <= '1;
                addr_r  <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_FLOOR1: begin
          f1_r    <= prod >>> 16;
          state_r <= S_FLOOR2;
        end
        S_FLOOR2: begin
          if (lo_s > hi_s) begin
            state_r <= S_OUT;
          end else begin
            addr_r  <= AddrW'(lo_s);
            hi_r    <= AddrW'(hi_s);
            count_r <= LevelW'(hi_s - lo_s + 31'sd1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            recip_r <= recip_q;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          if (addr_r == hi_r) begin
            state_r <= S_OUT;
          end else begin
            addr_r  <= addr_r + AddrW'(1);
            state_r <= S_RD;
          end
        end
        S_READ1: state_r <= S_READ2;
        S_READ2: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, captured as the state machine enters its output state
  logic read_ok;
  assign read_ok = (bidx_r <= 9'(MaxLevels));
  always_ff @(posedge clk) begin
    if (state_r == S_READ2 && read_ok) begin
      out_boundaries_crossed  <= '0;
      out_mean_intensity_up   <= rd_r.j_up;
      out_flux_up             <= rd_r.h_up;
      out_pressure_up         <= rd_r.k_up;
      out_mean_intensity_down <= rd_r.j_dn;
      out_flux_down           <= -$signed({1'b0, rd_r.h_dn});
      out_pressure_down       <= rd_r.k_dn;
    end else if (state_r != S_OUT) begin
      // items leaving idle straight for the output state cross nothing
      out_boundaries_crossed  <= (state_r == S_IDLE) ? '0 : count_r;
      out_mean_intensity_up   <= '0;
      out_flux_up             <= '0;
      out_pressure_up         <= '0;
      out_mean_intensity_down <= '0;
      out_flux_down           <= '0;
      out_pressure_down       <= '0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire

// File: src/srmt_recip.sv
// Restoring divider: 2^31 / m for a 16-bit magnitude m, one quotient bit a cycle.
// No dependencies.
`default_nettype none
module srmt_recip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] trial;
  logic        bit_in;

  // dividend 2^31: only bit 31 set
  assign bit_in = (cnt_r == 6'd31);
  assign trial  = {rem_r, bit_in} - {2'b00, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 6'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], bit_in};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = busy_r && (cnt_r == 6'd0);
  assign quotient = q_nxt;
endmodule
`default_nettype wire

// File: src/srmt_checker.sv
// Port-level checker for the slab radiation moment tally, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module srmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  out_boundaries_crossed,
  input logic [31:0] out_flux_up
);
  // no new item while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // an accepted item takes the block busy
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // a result with crossings never carries an upward flux
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_boundaries_crossed != '0) |-> out_flux_up == '0)
    else $error("step result carries tallies");
  // result holds while stalled: valid and crossing count stay
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_boundaries_crossed))
    else $error("result dropped");
endmodule

bind slab_radiation_moment_tally srmt_checker u_srmt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_boundaries_crossed(out_boundaries_crossed), .out_flux_up(out_flux_up)
);
`default_nettype wire

// File: tb/srmt_tally_checker.sv
// Checker for the slab radiation moment tally: watches the in_, out_ and cfg_ channels,
// keeps its own boundary store, predicts each result and compares it. Depends on srmt_pkg.
`default_nettype none
module srmt_tally_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic signed [19:0] in_start_height,
  input  logic signed [19:0] in_end_height,
  input  logic signed [15:0] in_direction_cosine,
  input  logic [8:0]        in_boundary_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [8:0]        out_boundaries_crossed,
  input  logic [47:0]       out_mean_intensity_up,
  input  logic [31:0]       out_flux_up,
  input  logic [47:0]       out_pressure_up,
  input  logic [47:0]       out_mean_intensity_down,
  input  logic signed [32:0] out_flux_down,
  input  logic [47:0]       out_pressure_down,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [8:0]        cfg_num_levels,
  output int                fails,
  output int                pending
);
  import srmt_pkg::*;

  typedef struct packed {
    logic [8:0]  crossed;
    logic [47:0] j_up;
    logic [31:0] h_up;
    logic [47:0] k_up;
    logic [47:0] j_dn;
    logic [32:0] h_dn;
    logic [47:0] k_dn;
  } moments_t;

  // model store; downward H kept as a crossing count
  logic [47:0] j_up_q [Depth];
  logic [31:0] h_up_q [Depth];
  logic [47:0] k_up_q [Depth];
  logic [47:0] j_dn_q [Depth];
  logic [31:0] h_dn_q [Depth];
  logic [47:0] k_dn_q [Depth];
  logic [8:0]  levels;
  moments_t    moments_due [$];

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  task automatic wipe_store();
    for (int k = 0; k < Depth; k++) begin
      j_up_q[k] = '0; h_up_q[k] = '0; k_up_q[k] = '0;
      j_dn_q[k] = '0; h_dn_q[k] = '0; k_dn_q[k] = '0;
    end
  endtask

  // apply one item to the store and work out its result
  task automatic tally_item(input logic [1:0] act, input logic signed [19:0] zs,
                            input logic signed [19:0] ze, input logic signed [15:0] mu,
                            input logic [8:0] bi, output moments_t r);
    longint n, f1, f2, lo, hi, mag;
    logic [47:0] recip, kinc;
    r = '0;
    case (act)
      ACT_STEP: begin
        n = levels;
        if (n < 1) n = 1;
        if (n > MaxLevels) n = MaxLevels;
        mag = mu;
        if (mag < 0) mag = -mag;
        if (mag != 0) begin
          recip = 48'((64'd1 << 31) / mag);
          kinc  = 48'(mag << 1);
          // floor(z*N) with Q16 heights: arithmetic shift floors
          f1 = (longint'(zs) * n) >>> 16;
          f2 = (longint'(ze) * n) >>> 16;
          if (mu > 0) begin
            lo = f1 + 1; hi = f2;
          end else begin
            lo = f2 + 1; hi = f1;
          end
          if (lo < 0) lo = 0;
          if (hi > n) hi = n;
          if (lo <= hi) begin
            for (longint k = lo; k <= hi; k++) begin
              if (mu > 0) begin
                j_up_q[k] = sat48(j_up_q[k], recip);
                if (h_up_q[k] != '1) h_up_q[k]++;
                k_up_q[k] = sat48(k_up_q[k], kinc);
              end else begin
                j_dn_q[k] = sat48(j_dn_q[k], recip);
                if (h_dn_q[k] != '1) h_dn_q[k]++;
                k_dn_q[k] = sat48(k_dn_q[k], kinc);
              end
            end
            r.crossed = 9'(hi - lo + 1);
          end
        end
      end
      ACT_READ: begin
        if (bi <= MaxLevels) begin
          r.j_up = j_up_q[bi];
          r.h_up = h_up_q[bi];
          r.k_up = k_up_q[bi];
          r.j_dn = j_dn_q[bi];
          r.h_dn = -{1'b0, h_dn_q[bi]};
          r.k_dn = k_dn_q[bi];
        end
      end
      ACT_CLEAR: wipe_store();
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("tally mismatch on %s: got %h, expected %h", what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    levels = 9'd256;
    wipe_store();
  end

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    moments_t r, w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) levels = cfg_num_levels;
      if (in_valid && in_ready) begin
        tally_item(in_action, in_start_height, in_end_height, in_direction_cosine,
                   in_boundary_index, r);
        moments_due.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (moments_due.size() == 0) begin
          flag_mismatch("unexpected item", 64'd1, 64'd0);
        end else begin
          w = moments_due.pop_front();
          if (out_boundaries_crossed !== w.crossed)
            flag_mismatch("boundaries_crossed", 64'(out_boundaries_crossed), 64'(w.crossed));
          if (out_mean_intensity_up !== w.j_up)
            flag_mismatch("mean_intensity_up", 64'(out_mean_intensity_up), 64'(w.j_up));
          if (out_flux_up !== w.h_up)
            flag_mismatch("flux_up", 64'(out_flux_up), 64'(w.h_up));
          if (out_pressure_up !== w.k_up)
            flag_mismatch("pressure_up", 64'(out_pressure_up), 64'(w.k_up));
          if (out_mean_intensity_down !== w.j_dn)
            flag_mismatch("mean_intensity_down", 64'(out_mean_intensity_down), 64'(w.j_dn));
          if (out_flux_down !== w.h_dn)
            flag_mismatch("flux_down", 64'(unsigned'(out_flux_down)), 64'(w.h_dn));
          if (out_pressure_down !== w.k_dn)
            flag_mismatch("pressure_down", 64'(out_pressure_down), 64'(w.k_dn));
        end
      end
      pending = moments_due.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench top for the slab radiation moment tally: clock, reset, stimulus and verdict.
// Depends on srmt_pkg, slab_radiation_moment_tally and srmt_tally_checker.
`default_nettype none
module tb;
  import srmt_pkg::*;

  localparam int PhaseItems = 78;
  localparam int CycleLimit = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] in_action;
  logic signed [19:0] in_start_height, in_end_height;
  logic signed [15:0] in_direction_cosine;
  logic [8:0] in_boundary_index, cfg_num_levels;
  logic [8:0] out_boundaries_crossed;
  logic [47:0] out_mean_intensity_up, out_pressure_up;
  logic [47:0] out_mean_intensity_down, out_pressure_down;
  logic [31:0] out_flux_up;
  logic signed [32:0] out_flux_down;
  int fails, pending;

  int  items_sent;
  int  hold_cycles;
  bit  quiet;
  int  cur_levels;
  longint cycles;

  slab_radiation_moment_tally u_top (.*);

  srmt_tally_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold-off, none at the end
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one item and hold it until taken
  task automatic drive_item(input logic [1:0] act, input logic signed [19:0] zs,
                            input logic signed [19:0] ze, input logic signed [15:0] mu,
                            input logic [8:0] bi);
    int gap;
    gap = 0;
    if (!quiet && ((items_sent / 40) % 3 != 2) && $urandom_range(0, 4) == 0)
      gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= act;
    in_start_height     <= zs;
    in_end_height       <= ze;
    in_direction_cosine <= mu;
    in_boundary_index   <= bi;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (items_sent == 200) hold_cycles = 3000;
  endtask

  // new layer count, written once the block has drained
  task automatic set_levels(input logic [8:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_num_levels <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_levels = (v == 0) ? 1 : ((v > MaxLevels) ? MaxLevels : v);
  endtask

  // random item: mostly well-formed steps and reads, some noise
  task automatic random_item();
    int sel;
    logic signed [19:0] zs, ze, tmp;
    logic signed [15:0] mu;
    logic [8:0] bi;
    sel = $urandom_range(0, 199);
    zs = 20'($urandom);
    ze = 20'($urandom);
    mu = 16'($urandom);
    bi = 9'($urandom);
    if (sel < 140) begin
      case ($urandom_range(0, 9))
        0:       ;
        1, 2, 3: begin
          zs = 20'($signed($urandom_range(0, 90112)) - 8192);
          ze = 20'(zs + $signed($urandom_range(0, 8192)) - 4096);
        end
        default: begin
          zs = 20'($signed($urandom_range(0, 90112)) - 8192);
          ze = 20'($signed($urandom_range(0, 90112)) - 8192);
        end
      endcase
      case ($urandom_range(0, 19))
        0:       mu = '0;
        1:       mu = 16'sd1;
        2:       mu = -16'sd1;
        3:       mu = 16'sh7fff;
        4:       mu = 16'sh8000;
        default: if (mu == 0) mu = 16'sd5;
      endcase
      // keep most steps moving the way the cosine points
      if ($urandom_range(0, 3) != 0 && ((mu > 0) != (ze >= zs))) begin
        tmp = zs; zs = ze; ze = tmp;
      end
      drive_item(ACT_STEP, zs, ze, mu, bi);
    end else if (sel < 192) begin
      if ($urandom_range(0, 9) != 0) bi = 9'($urandom_range(0, cur_levels));
      drive_item(ACT_READ, zs, ze, mu, bi);
    end else if (sel < 196) begin
      drive_item(ACT_CLEAR, zs, ze, mu, bi);
    end else begin
      drive_item(2'd3, zs, ze, mu, bi);
    end
  endtask

  initial begin
    logic [8:0] plan [8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_STEP;
    in_start_height = '0;
    in_end_height = '0;
    in_direction_cosine = '0;
    in_boundary_index = '0;
    cfg_valid = 1'b0;
    cfg_num_levels = '0;
    items_sent = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    cur_levels = MaxLevels;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, empty ranges, zero cosine, reads past the store
    drive_item(ACT_READ, '0, '0, '0, 9'd0);
    drive_item(ACT_STEP, 20'sh80000, 20'sh7ffff, 16'sh7fff, '0);
    drive_item(ACT_STEP, 20'sh7ffff, 20'sh80000, 16'sh8000, '1);
    drive_item(ACT_STEP, 20'sd0, 20'sd65536, 16'sd1, '0);
    drive_item(ACT_STEP, 20'sd65536, 20'sd0, -16'sd1, '0);
    drive_item(ACT_STEP, 20'sd100, 20'sd70000, 16'sd0, '0);
    drive_item(ACT_STEP, 20'sd60000, 20'sd100, 16'sd12000, '0);
    drive_item(ACT_STEP, 20'sd0, 20'sd256, 16'sd3, '0);
    drive_item(ACT_STEP, 20'sd256, 20'sd0, -16'sd3, '0);
    drive_item(ACT_READ, '0, '0, '0, 9'd0);
    drive_item(ACT_READ, '0, '0, '0, 9'd1);
    drive_item(ACT_READ, '0, '0, '0, 9'd128);
    drive_item(ACT_READ, '0, '0, '0, 9'd256);
    drive_item(ACT_READ, '1, '1, '1, 9'd257);
    drive_item(ACT_READ, '0, '0, '0, 9'd511);
    drive_item(2'd3, 20'sh12345, 20'sh6789a, 16'sh1234, 9'd5);
    drive_item(ACT_CLEAR, '0, '0, '0, '0);
    drive_item(ACT_READ, '0, '0, '0, 9'd256);
    drive_item(ACT_READ, '0, '0, '0, 9'd1);

    // phases over layer counts, extremes and out-of-range values among them
    plan = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd200, 9'd3, 9'($urandom_range(2, 255)), 9'd256};
    for (int p = 0; p < 8; p++) begin
      set_levels(plan[p]);
      if (p == 7) quiet = 1'b1;
      repeat (PhaseItems) random_item();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
src/srmt_pkg.sv
src/srmt_recip.sv
src/slab_radiation_moment_tally.sv
src/srmt_checker.sv
tb/srmt_tally_checker.sv
tb/tb.sv
